### sv/vna_pkg.sv
// Shared types, widths and constants of the vector normalize and analyze pipeline.
`default_nettype none
package vna_pkg;

    localparam int NCOMP   = 7;    // component slots on the ports
    localparam int COMP_W  = 16;   // Q3.12 component
    localparam int ABS_W   = 17;   // magnitude of one component
    localparam int SQ_W    = 31;   // one squared component
    localparam int SS_W    = 36;   // sum of squares, padded to an even width
    localparam int ROOT_W  = 18;   // root register, one bit per sqrt cell
    localparam int REM_W   = 20;   // sqrt partial remainder
    localparam int MAG_W   = 17;   // Q5.12 magnitude
    localparam int SUM_W   = 19;   // signed component sum
    localparam int S_W     = 18;   // positive component sum
    localparam int DREM_W  = 31;   // divider partial remainder
    localparam int QUO_W   = 15;   // quotient of one lane
    localparam int DIV_FRAC = 14;  // Q1.14 result
    localparam int X_W     = 68;   // coherence remainder
    localparam int Y_W     = 36;   // DIM * mag^2
    localparam int P_W     = 52;   // c * Y
    localparam int COH_W   = 16;
    localparam int COH_FRAC = 15;
    localparam int AXIS_W  = 3;
    localparam int NORM_W  = 16;
    localparam int SQRT_CELLS = ROOT_W;
    localparam int DIV_CELLS  = QUO_W;
    localparam int S_TDATA_W  = 112;
    localparam int M_TDATA_W  = 152;
    localparam logic [COH_W-1:0] COH_ONE = 16'd32768;

    typedef logic [NCOMP-1:0][DREM_W-1:0] drem_t;
    typedef logic [NCOMP-1:0][QUO_W-1:0]  quo_t;

    // Per-beat data that rides beside the arithmetic cells.
    typedef struct packed {
        logic [NCOMP-1:0][ABS_W-1:0] absv;
        logic [NCOMP-1:0]            neg;
        logic                        sum_pos;
        logic [S_W-1:0]              s;
        logic [AXIS_W-1:0]           axis;
        logic [MAG_W-1:0]            mag;
        logic                        zero;
        logic                        full;
    } side_t;

    // round(16384 / sqrt(dim))
    function automatic logic [NORM_W-1:0] uniform_value(input int dim);
        logic [NORM_W-1:0] u;
        u = 16'd0;
        case (dim)
            1:       u = 16'd16384;
            2:       u = 16'd11585;
            3:       u = 16'd9459;
            4:       u = 16'd8192;
            5:       u = 16'd7327;
            6:       u = 16'd6689;
            7:       u = 16'd6193;
            8:       u = 16'd5793;
            default: u = 16'd0;
        endcase
        return u;
    endfunction

endpackage
`default_nettype wire

### sv/vna_sqrt_cell.sv
// One bit of the integer square root: two radicand bits in, one root bit out.
`default_nettype none
module vna_sqrt_cell #(
    parameter int K = 0
) (
    input  wire logic                          aclk,
    input  wire logic                          en,
    input  wire logic [vna_pkg::SS_W-1:0]      val_i,
    input  wire logic [vna_pkg::REM_W-1:0]     rem_i,
    input  wire logic [vna_pkg::ROOT_W-1:0]    root_i,
    output logic      [vna_pkg::SS_W-1:0]      val_o,
    output logic      [vna_pkg::REM_W-1:0]     rem_o,
    output logic      [vna_pkg::ROOT_W-1:0]    root_o
);
    logic [vna_pkg::SS_W-1:0]   val_reg;
    logic [vna_pkg::REM_W-1:0]  rem_reg, rem_next;
    logic [vna_pkg::ROOT_W-1:0] root_reg, root_next;
    logic [vna_pkg::REM_W+1:0]  tmp;
    logic [vna_pkg::REM_W-1:0]  trial;

    always_comb begin
        tmp   = {rem_i, val_i[2*K+1 -: 2]};
        trial = {root_i, 2'b01};
        if (tmp >= {2'b00, trial}) begin
            rem_next  = vna_pkg::REM_W'(tmp - {2'b00, trial});
            root_next = {root_i[vna_pkg::ROOT_W-2:0], 1'b1};
        end else begin
            rem_next  = tmp[vna_pkg::REM_W-1:0];
            root_next = {root_i[vna_pkg::ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            val_reg  <= val_i;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign val_o  = val_reg;
    assign rem_o  = rem_reg;
    assign root_o = root_reg;
endmodule
`default_nettype wire

### sv/vna_div_cell.sv
// One quotient bit for every component lane of the normalizing divide.
`default_nettype none
module vna_div_cell #(
    parameter int K = 0
) (
    input  wire logic                        aclk,
    input  wire logic                        en,
    input  wire logic [vna_pkg::MAG_W-1:0]   mag_i,
    input  wire vna_pkg::drem_t              rem_i,
    input  wire vna_pkg::quo_t               q_i,
    output logic      [vna_pkg::MAG_W-1:0]   mag_o,
    output vna_pkg::drem_t                   rem_o,
    output vna_pkg::quo_t                    q_o
);
    logic [vna_pkg::MAG_W-1:0]  mag_reg;
    vna_pkg::drem_t             rem_reg, rem_next;
    vna_pkg::quo_t              q_reg, q_next;
    logic [vna_pkg::DREM_W-1:0] trial;

    always_comb begin
        trial = vna_pkg::DREM_W'(mag_i) << K;
        for (int i = 0; i < vna_pkg::NCOMP; i++) begin
            if (rem_i[i] >= trial) begin
                rem_next[i] = rem_i[i] - trial;
                q_next[i]   = q_i[i] | (vna_pkg::QUO_W'(1) << K);
            end else begin
                rem_next[i] = rem_i[i];
                q_next[i]   = q_i[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag_reg <= mag_i;
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    assign mag_o = mag_reg;
    assign rem_o = rem_reg;
    assign q_o   = q_reg;
endmodule
`default_nettype wire

### sv/vna_coh_cell.sv
// One bit of the coherence root: largest c with c^2 * Y <= X, tracked as X - c^2*Y.
`default_nettype none
module vna_coh_cell #(
    parameter int K = 0
) (
    input  wire logic                        aclk,
    input  wire logic                        en,
    input  wire logic [vna_pkg::X_W-1:0]     r_i,
    input  wire logic [vna_pkg::P_W-1:0]     p_i,
    input  wire logic [vna_pkg::Y_W-1:0]     y_i,
    input  wire logic [vna_pkg::QUO_W-1:0]   c_i,
    output logic      [vna_pkg::X_W-1:0]     r_o,
    output logic      [vna_pkg::P_W-1:0]     p_o,
    output logic      [vna_pkg::Y_W-1:0]     y_o,
    output logic      [vna_pkg::QUO_W-1:0]   c_o
);
    logic [vna_pkg::X_W-1:0]   r_reg, r_next, t;
    logic [vna_pkg::P_W-1:0]   p_reg, p_next;
    logic [vna_pkg::Y_W-1:0]   y_reg;
    logic [vna_pkg::QUO_W-1:0] c_reg, c_next;

    // (c + 2^K)^2 Y - c^2 Y = 2^(K+1) cY + 2^(2K) Y
    always_comb begin
        t = (vna_pkg::X_W'(p_i) << (K + 1)) + (vna_pkg::X_W'(y_i) << (2 * K));
        if (r_i >= t) begin
            r_next = r_i - t;
            p_next = p_i + (vna_pkg::P_W'(y_i) << K);
            c_next = c_i | (vna_pkg::QUO_W'(1) << K);
        end else begin
            r_next = r_i;
            p_next = p_i;
            c_next = c_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg <= r_next;
            p_reg <= p_next;
            y_reg <= y_i;
            c_reg <= c_next;
        end
    end

    assign r_o = r_reg;
    assign p_o = p_reg;
    assign y_o = y_reg;
    assign c_o = c_reg;
endmodule
`default_nettype wire

### sv/vector_normalize_analyze.sv
// Top level: L2 normalization, magnitude, coherence and dominant axis of one vector.
//
//  channel | dir | payload
//  s_      | in  | tdata: comp_0..comp_6, 16 bits each
//  m_      | out | tdata: norm_0..norm_6, magnitude, coherence, dominant_axis; tuser: was_zero
//
// One beat accepted per cycle while no output beat waits.
// 38 register stages: two front stages, the sqrt cell row (18 cells), two prep stages,
// the divide/coherence cell row (15 cells) and the output register.
// The whole pipeline advances together; it stalls only while an output beat waits.
// Reset clears the valid line only.
`default_nettype none
module vector_normalize_analyze #(
    parameter int DIM = 7
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // comp_0 [15:0] .. comp_6 [111:96]
    input  wire logic [vna_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // norm_0 [15:0] .. norm_6 [111:96], magnitude [128:112], coherence [144:129],
    // dominant_axis [147:145], zero pad [151:148]
    output logic [vna_pkg::M_TDATA_W-1:0]          m_tdata,
    // was_zero [0]
    output logic                                   m_tuser
);
    localparam int NUSED  = (DIM < vna_pkg::NCOMP) ? DIM : vna_pkg::NCOMP;
    localparam int ST_SQ0 = 2;
    localparam int ST_P1  = ST_SQ0 + vna_pkg::SQRT_CELLS;
    localparam int ST_P2  = ST_P1 + 1;
    localparam int ST_D0  = ST_P2 + 1;
    localparam int ST_OUT = ST_D0 + vna_pkg::DIV_CELLS;
    localparam int NST    = ST_OUT + 1;
    localparam logic [vna_pkg::NORM_W-1:0] UNI = vna_pkg::uniform_value(DIM);

    logic en;
    logic [NST-1:0] vld_reg;

    vna_pkg::side_t side_reg  [NST-1];
    vna_pkg::side_t side_next [NST-1];
    vna_pkg::side_t side0_next;

    // stage 0 / 1 arithmetic
    logic [vna_pkg::NCOMP-1:0][vna_pkg::SQ_W-1:0] sq_reg, sq_next;
    logic [vna_pkg::SS_W-1:0]                     ss_reg, ss_next;

    // prep stages
    logic [2*vna_pkg::MAG_W-1:0] mag2_reg;
    logic [vna_pkg::Y_W-1:0]     s2_reg;
    logic [vna_pkg::Y_W-1:0]     y_reg, y_next;
    logic [vna_pkg::X_W-1:0]     x_reg;
    vna_pkg::drem_t              drem0_reg, drem0_next;

    // cell rows
    logic [vna_pkg::SS_W-1:0]   sv_val  [vna_pkg::SQRT_CELLS+1];
    logic [vna_pkg::REM_W-1:0]  sv_rem  [vna_pkg::SQRT_CELLS+1];
    logic [vna_pkg::ROOT_W-1:0] sv_root [vna_pkg::SQRT_CELLS+1];
    logic [vna_pkg::MAG_W-1:0]  dv_mag  [vna_pkg::DIV_CELLS+1];
    vna_pkg::drem_t             dv_rem  [vna_pkg::DIV_CELLS+1];
    vna_pkg::quo_t              dv_q    [vna_pkg::DIV_CELLS+1];
    logic [vna_pkg::X_W-1:0]    ch_r    [vna_pkg::DIV_CELLS+1];
    logic [vna_pkg::P_W-1:0]    ch_p    [vna_pkg::DIV_CELLS+1];
    logic [vna_pkg::Y_W-1:0]    ch_y    [vna_pkg::DIV_CELLS+1];
    logic [vna_pkg::QUO_W-1:0]  ch_c    [vna_pkg::DIV_CELLS+1];

    logic [vna_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                          m_tuser_reg, m_tuser_next;

    assign en       = m_tready || !vld_reg[NST-1];
    assign s_tready = en;
    assign m_tvalid = vld_reg[NST-1];
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NST-2:0], s_tvalid};
        end
    end

    // stage 0: abs, squares, sum, dominant axis
    always_comb begin
        logic signed [vna_pkg::COMP_W-1:0] c;
        logic [vna_pkg::ABS_W-1:0]         a, best;
        logic signed [vna_pkg::SUM_W-1:0]  sum;
        side0_next = '0;
        sq_next    = '0;
        sum        = '0;
        best       = '0;
        for (int i = 0; i < NUSED; i++) begin
            c = signed'(s_tdata[vna_pkg::COMP_W*i +: vna_pkg::COMP_W]);
            a = c[vna_pkg::COMP_W-1] ? vna_pkg::ABS_W'(-{c[vna_pkg::COMP_W-1], c})
                                     : vna_pkg::ABS_W'({1'b0, c});
            side0_next.absv[i] = a;
            side0_next.neg[i]  = c[vna_pkg::COMP_W-1];
            sq_next[i] = vna_pkg::SQ_W'(a * a);
            sum = sum + vna_pkg::SUM_W'(c);
            if (i == 0 || a > best) begin
                best = a;
                side0_next.axis = vna_pkg::AXIS_W'(i);
            end
        end
        side0_next.sum_pos = !sum[vna_pkg::SUM_W-1] && (sum != '0);
        side0_next.s       = sum[vna_pkg::S_W-1:0];
    end

    // stage 1: sum of squares
    always_comb begin
        ss_next = '0;
        for (int i = 0; i < vna_pkg::NCOMP; i++) begin
            ss_next = ss_next + vna_pkg::SS_W'(sq_reg[i]);
        end
    end

    // side line, with fields filled in where they become known
    always_comb begin
        side_next[0] = side0_next;
        for (int n = 1; n < NST - 1; n++) begin
            side_next[n] = side_reg[n-1];
            if (n == ST_P1) begin
                side_next[n].mag  = sv_root[vna_pkg::SQRT_CELLS][vna_pkg::MAG_W-1:0];
                side_next[n].zero = (sv_root[vna_pkg::SQRT_CELLS] == '0);
            end
            if (n == ST_P2) begin
                side_next[n].full = (y_next <= s2_reg);
            end
        end
    end

    // prep stage 2 inputs
    always_comb begin
        y_next = vna_pkg::Y_W'(mag2_reg * unsigned'(4'(DIM)));
        for (int i = 0; i < vna_pkg::NCOMP; i++) begin
            drem0_next[i] = vna_pkg::DREM_W'(side_reg[ST_P1].absv[i]) << vna_pkg::DIV_FRAC;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int n = 0; n < NST - 1; n++) begin
                side_reg[n] <= side_next[n];
            end
            sq_reg    <= sq_next;
            ss_reg    <= ss_next;
            mag2_reg  <= (2*vna_pkg::MAG_W)'(side_next[ST_P1].mag * side_next[ST_P1].mag);
            s2_reg    <= vna_pkg::Y_W'(side_reg[ST_P1-1].s * side_reg[ST_P1-1].s);
            y_reg     <= y_next;
            x_reg     <= vna_pkg::X_W'(s2_reg) << (2 * vna_pkg::COH_FRAC);
            drem0_reg <= drem0_next;
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    // square root row
    assign sv_val[0]  = ss_reg;
    assign sv_rem[0]  = '0;
    assign sv_root[0] = '0;

    for (genvar j = 0; j < vna_pkg::SQRT_CELLS; j++) begin : g_sqrt
        vna_sqrt_cell #(.K(vna_pkg::SQRT_CELLS - 1 - j)) u_cell (
            .aclk   (aclk),
            .en     (en),
            .val_i  (sv_val[j]),
            .rem_i  (sv_rem[j]),
            .root_i (sv_root[j]),
            .val_o  (sv_val[j+1]),
            .rem_o  (sv_rem[j+1]),
            .root_o (sv_root[j+1])
        );
    end

    // divide and coherence rows run side by side
    assign dv_mag[0] = side_reg[ST_P2].mag;
    assign dv_rem[0] = drem0_reg;
    assign dv_q[0]   = '0;
    assign ch_r[0]   = x_reg;
    assign ch_p[0]   = '0;
    assign ch_y[0]   = y_reg;
    assign ch_c[0]   = '0;

    for (genvar j = 0; j < vna_pkg::DIV_CELLS; j++) begin : g_div
        vna_div_cell #(.K(vna_pkg::DIV_CELLS - 1 - j)) u_div (
            .aclk  (aclk),
            .en    (en),
            .mag_i (dv_mag[j]),
            .rem_i (dv_rem[j]),
            .q_i   (dv_q[j]),
            .mag_o (dv_mag[j+1]),
            .rem_o (dv_rem[j+1]),
            .q_o   (dv_q[j+1])
        );
        vna_coh_cell #(.K(vna_pkg::DIV_CELLS - 1 - j)) u_coh (
            .aclk (aclk),
            .en   (en),
            .r_i  (ch_r[j]),
            .p_i  (ch_p[j]),
            .y_i  (ch_y[j]),
            .c_i  (ch_c[j]),
            .r_o  (ch_r[j+1]),
            .p_o  (ch_p[j+1]),
            .y_o  (ch_y[j+1]),
            .c_o  (ch_c[j+1])
        );
    end

    // output assembly
    always_comb begin
        vna_pkg::side_t             sd;
        logic [vna_pkg::NORM_W-1:0] q;
        logic [vna_pkg::COH_W-1:0]  coh;
        sd = side_reg[NST-2];
        m_tdata_next = '0;
        for (int i = 0; i < NUSED; i++) begin
            q = vna_pkg::NORM_W'(dv_q[vna_pkg::DIV_CELLS][i]);
            if (sd.zero) begin
                m_tdata_next[vna_pkg::NORM_W*i +: vna_pkg::NORM_W] = UNI;
            end else begin
                m_tdata_next[vna_pkg::NORM_W*i +: vna_pkg::NORM_W] = sd.neg[i] ? -q : q;
            end
        end
        if (sd.zero || (sd.sum_pos && sd.full)) begin
            coh = vna_pkg::COH_ONE;
        end else if (!sd.sum_pos) begin
            coh = '0;
        end else begin
            coh = vna_pkg::COH_W'(ch_c[vna_pkg::DIV_CELLS]);
        end
        m_tdata_next[128:112] = sd.mag;
        m_tdata_next[144:129] = coh;
        m_tdata_next[147:145] = sd.zero ? '0 : sd.axis;
        m_tuser_next = sd.zero;
    end

`ifndef NO_ASSERTIONS
    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> vld_reg[0])
        else $error("accepted beat did not enter the pipeline");
    a_zero_mag: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[128:112] == '0 && m_tdata[144:129] == vna_pkg::COH_ONE))
        else $error("zero beat with nonzero magnitude or partial coherence");
    a_nonzero_mag: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata[128:112] != '0))
        else $error("nonzero beat with zero magnitude");
    a_coh_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[144:129] <= vna_pkg::COH_ONE))
        else $error("coherence out of range");
`endif
endmodule
`default_nettype wire
